@@ rtl/perspective_point_projector_defines.svh @@
// assertion macros for the perspective point projector
`ifndef PERSPECTIVE_POINT_PROJECTOR_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTOR_DEFINES_SVH

// same-cycle implication under reset
`define PPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define PPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ppp_pkg.sv @@
// shared types, widths and helpers of the perspective point projector
`default_nettype none
package ppp_pkg;
  localparam int COORD_WIDTH    = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_W  = 16;
  localparam int PROD_W  = COORD_WIDTH + COEF_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int MAG_W   = ACC_W - 1;
  localparam int REG12_W = 12;
  localparam int NUM_W   = MAG_W + REG12_W;
  localparam int DEN_W   = MAG_W;
  localparam int QW      = NUM_W;
  localparam int SAT_W   = QW + 3;
  localparam int OUT_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int LATENCY = 3 + QW + 1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFF    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFF    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd6;

  typedef struct packed {
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [DEN_W-1:0] rem_x;
    logic [DEN_W-1:0] rem_y;
    logic [QW-1:0]    q_x;
    logic [QW-1:0]    q_y;
    logic [DEN_W-1:0] den;
    logic             neg_x;
    logic             neg_y;
    logic             zero;
  } div_t;

  // clamp to 16-bit signed, msb of result flags a clamp
  function automatic logic [OUT_W:0] sat16(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    logic [OUT_W:0] res;
    hi = SAT_W'(32767);
    lo = -SAT_W'(32768);
    if (v > hi) begin
      res = {1'b1, 16'h7fff};
    end else if (v < lo) begin
      res = {1'b1, 16'h8000};
    end else begin
      res = {1'b0, v[OUT_W-1:0]};
    end
    return res;
  endfunction
endpackage
`default_nettype wire

@@ rtl/ppp_front.sv @@
// view transform, magnitudes and numerator scaling ahead of the divider chain
`default_nettype none
module ppp_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               vld_i,
  input  wire logic signed [ppp_pkg::COORD_WIDTH-1:0] wx_i,
  input  wire logic signed [ppp_pkg::COORD_WIDTH-1:0] wy_i,
  input  wire logic signed [ppp_pkg::COORD_WIDTH-1:0] wz_i,
  input  wire logic [63:0]                        row_x_i,
  input  wire logic [63:0]                        row_y_i,
  input  wire logic [63:0]                        row_d_i,
  input  wire logic [ppp_pkg::REG12_W-1:0]        dist_i,
  output logic                                    vld_o,
  output ppp_pkg::div_t                           div_o
);
  logic [63:0] rows [3];
  logic signed [ppp_pkg::PROD_W-1:0] prod_r [3][3];
  logic signed [ppp_pkg::ACC_W-1:0]  acc_r [3];
  logic signed [ppp_pkg::ACC_W-1:0]  acc_nxt [3];
  logic [ppp_pkg::MAG_W-1:0]         mag [3];
  logic                              vld1_r, vld2_r, vld3_r;
  ppp_pkg::div_t                     div_r;
  ppp_pkg::div_t                     div_nxt;

  assign rows[0] = row_x_i;
  assign rows[1] = row_y_i;
  assign rows[2] = row_d_i;

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      prod_r[r][0] <= $signed(rows[r][15:0])  * wx_i;
      prod_r[r][1] <= $signed(rows[r][31:16]) * wy_i;
      prod_r[r][2] <= $signed(rows[r][47:32]) * wz_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = ppp_pkg::ACC_W'(prod_r[r][0]) + ppp_pkg::ACC_W'(prod_r[r][1])
                 + ppp_pkg::ACC_W'(prod_r[r][2])
                 + (ppp_pkg::ACC_W'($signed(rows[r][63:48])) <<< ppp_pkg::COEF_FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      acc_r[r] <= acc_nxt[r];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag[r] = acc_r[r][ppp_pkg::ACC_W-1] ? ppp_pkg::MAG_W'(-acc_r[r])
                                           : ppp_pkg::MAG_W'(acc_r[r]);
    end
    div_nxt.num_x = ppp_pkg::NUM_W'(dist_i) * ppp_pkg::NUM_W'(mag[0]);
    div_nxt.num_y = ppp_pkg::NUM_W'(dist_i) * ppp_pkg::NUM_W'(mag[1]);
    div_nxt.rem_x = '0;
    div_nxt.rem_y = '0;
    div_nxt.q_x   = '0;
    div_nxt.q_y   = '0;
    div_nxt.den   = mag[2];
    div_nxt.neg_x = acc_r[0][ppp_pkg::ACC_W-1] ^ acc_r[2][ppp_pkg::ACC_W-1];
    div_nxt.neg_y = acc_r[1][ppp_pkg::ACC_W-1] ^ acc_r[2][ppp_pkg::ACC_W-1];
    div_nxt.zero  = (acc_r[2] == '0);
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  assign vld_o = vld3_r;
  assign div_o = div_r;
endmodule
`default_nettype wire

@@ rtl/ppp_div_cell.sv @@
// one restoring division step for both quotients, registered
`default_nettype none
module ppp_div_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_i,
  input  ppp_pkg::div_t      div_i,
  output logic               vld_o,
  output ppp_pkg::div_t      div_o
);
  logic [ppp_pkg::DEN_W:0] rx, ry, dx, dy, den_e;
  logic                    gex, gey;
  logic                    vld_r;
  ppp_pkg::div_t           div_r;
  ppp_pkg::div_t           div_nxt;

  always_comb begin
    den_e = {1'b0, div_i.den};
    rx  = {div_i.rem_x, div_i.num_x[ppp_pkg::NUM_W-1]};
    ry  = {div_i.rem_y, div_i.num_y[ppp_pkg::NUM_W-1]};
    dx  = rx - den_e;
    dy  = ry - den_e;
    gex = (rx >= den_e);
    gey = (ry >= den_e);
    div_nxt       = div_i;
    div_nxt.num_x = div_i.num_x << 1;
    div_nxt.num_y = div_i.num_y << 1;
    div_nxt.rem_x = gex ? dx[ppp_pkg::DEN_W-1:0] : rx[ppp_pkg::DEN_W-1:0];
    div_nxt.rem_y = gey ? dy[ppp_pkg::DEN_W-1:0] : ry[ppp_pkg::DEN_W-1:0];
    div_nxt.q_x   = {div_i.q_x[ppp_pkg::QW-2:0], gex};
    div_nxt.q_y   = {div_i.q_y[ppp_pkg::QW-2:0], gey};
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  assign vld_o = vld_r;
  assign div_o = div_r;
endmodule
`default_nettype wire

@@ rtl/perspective_point_projector.sv @@
// top level: config registers, front end, divider chain and output stage
`default_nettype none
// Perspective point projector. One world point is taken per clock (busy stays low)
// and its result appears on the out_ ports with out_valid high for one cycle,
// after the front end's product, sum and numerator registers (view transform and
// numerator scaling), the 45 cells of the divider chain (one quotient bit per
// cell), and one output register. The receiver cannot stall, so results must be
// taken as they come. Configuration is taken every cycle (cfg_ready high) and
// should only change while no point is in flight.
module perspective_point_projector (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [ppp_pkg::COORD_WIDTH-1:0] in_world_x,
  input  wire logic signed [ppp_pkg::COORD_WIDTH-1:0] in_world_y,
  input  wire logic signed [ppp_pkg::COORD_WIDTH-1:0] in_world_z,
  output logic                                        out_valid,
  output logic signed [ppp_pkg::OUT_W-1:0]            out_screen_x,
  output logic signed [ppp_pkg::OUT_W-1:0]            out_screen_y,
  output logic                                        out_zero_depth,
  output logic                                        out_clipped,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [ppp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [63:0]                            cfg_data
);
  logic [63:0]                   row_x_r, row_y_r, row_d_r;
  logic [ppp_pkg::REG12_W-1:0]   dist_r, xoff_r, yoff_r, rows_r;
  logic                          vld_chain [ppp_pkg::QW+1];
  ppp_pkg::div_t                 div_chain [ppp_pkg::QW+1];
  ppp_pkg::div_t                 last;
  logic signed [ppp_pkg::SAT_W-1:0] qx, qy, sx, sy;
  logic [ppp_pkg::OUT_W:0]       satx, saty;
  logic                          ov_r;
  logic [ppp_pkg::OUT_W-1:0]     ox_r, oy_r, ox_nxt, oy_nxt;
  logic                          oz_r, oc_r, oz_nxt, oc_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= '0;
      row_y_r <= '0;
      row_d_r <= '0;
      dist_r  <= 12'd200;
      xoff_r  <= 12'd350;
      yoff_r  <= 12'd350;
      rows_r  <= 12'd700;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppp_pkg::REG_ROW_X: row_x_r <= cfg_data;
        ppp_pkg::REG_ROW_Y: row_y_r <= cfg_data;
        ppp_pkg::REG_ROW_D: row_d_r <= cfg_data;
        ppp_pkg::REG_DIST:  dist_r  <= cfg_data[ppp_pkg::REG12_W-1:0];
        ppp_pkg::REG_X_OFF: xoff_r  <= cfg_data[ppp_pkg::REG12_W-1:0];
        ppp_pkg::REG_Y_OFF: yoff_r  <= cfg_data[ppp_pkg::REG12_W-1:0];
        ppp_pkg::REG_ROWS:  rows_r  <= cfg_data[ppp_pkg::REG12_W-1:0];
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (start & ~busy),
    .wx_i    (in_world_x),
    .wy_i    (in_world_y),
    .wz_i    (in_world_z),
    .row_x_i (row_x_r),
    .row_y_i (row_y_r),
    .row_d_i (row_d_r),
    .dist_i  (dist_r),
    .vld_o   (vld_chain[0]),
    .div_o   (div_chain[0])
  );

  for (genvar i = 0; i < ppp_pkg::QW; i++) begin : g_cell
    ppp_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld_chain[i]),
      .div_i (div_chain[i]),
      .vld_o (vld_chain[i+1]),
      .div_o (div_chain[i+1])
    );
  end

  assign last = div_chain[ppp_pkg::QW];

  always_comb begin
    qx = last.neg_x ? -ppp_pkg::SAT_W'(last.q_x) : ppp_pkg::SAT_W'(last.q_x);
    qy = last.neg_y ? -ppp_pkg::SAT_W'(last.q_y) : ppp_pkg::SAT_W'(last.q_y);
    sx = qx + ppp_pkg::SAT_W'(xoff_r);
    sy = ppp_pkg::SAT_W'(rows_r) - (qy + ppp_pkg::SAT_W'(yoff_r));
    satx = ppp_pkg::sat16(sx);
    saty = ppp_pkg::sat16(sy);
    if (last.zero) begin
      ox_nxt = '0;
      oy_nxt = '0;
      oz_nxt = 1'b1;
      oc_nxt = 1'b0;
    end else begin
      ox_nxt = satx[ppp_pkg::OUT_W-1:0];
      oy_nxt = saty[ppp_pkg::OUT_W-1:0];
      oz_nxt = 1'b0;
      oc_nxt = satx[ppp_pkg::OUT_W] | saty[ppp_pkg::OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    ox_r <= ox_nxt;
    oy_r <= oy_nxt;
    oz_r <= oz_nxt;
    oc_r <= oc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= vld_chain[ppp_pkg::QW];
    end
  end

  assign out_valid      = ov_r;
  assign out_screen_x   = ox_r;
  assign out_screen_y   = oy_r;
  assign out_zero_depth = oz_r;
  assign out_clipped    = oc_r;
endmodule
`default_nettype wire

@@ rtl/ppp_checker.sv @@
// port-level checks of the perspective point projector, bound to the top level
`default_nettype none
`include "perspective_point_projector_defines.svh"
module ppp_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic [ppp_pkg::OUT_W-1:0]    out_screen_x,
  input wire logic [ppp_pkg::OUT_W-1:0]    out_screen_y,
  input wire logic                         out_zero_depth,
  input wire logic                         out_clipped
);
  // a result only follows an item taken a fixed latency earlier
  `PPP_ASSERT_NOW(a_latency, out_valid,
    $past(start && !busy, ppp_pkg::LATENCY), "result without matching item")
  `PPP_ASSERT_NOW(a_zero_out, out_valid && out_zero_depth,
    out_screen_x == '0 && out_screen_y == '0 && !out_clipped, "zero depth not cleared")
  `PPP_ASSERT_NOW(a_clip_edge, out_valid && out_clipped,
    out_screen_x == 16'h7fff || out_screen_x == 16'h8000 ||
    out_screen_y == 16'h7fff || out_screen_y == 16'h8000, "clip flag without a clamp")
  `PPP_ASSERT_NEXT(a_no_stall, 1'b1, !busy, "block refused an item")
endmodule

bind perspective_point_projector ppp_checker u_ppp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_screen_x   (out_screen_x),
  .out_screen_y   (out_screen_y),
  .out_zero_depth (out_zero_depth),
  .out_clipped    (out_clipped)
);
`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench of the perspective point projector
module testbench;
  import ppp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int N_PHASES = 8;
  localparam int PTS_PER_PHASE = 66;

  typedef struct {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
    logic                    zd;
    logic                    cl;
  } screen_pt_t;

  typedef enum logic [1:0] {ROW_POINT, ROW_POINT_KNOWN, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic signed [15:0]      x, y, z;
    logic [CFG_IDX_W-1:0]    idx;
    logic [63:0]             data;
    logic signed [OUT_W-1:0] sx, sy;
    logic                    zd, cl;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [COORD_WIDTH-1:0] in_world_x = '0;
  logic signed [COORD_WIDTH-1:0] in_world_y = '0;
  logic signed [COORD_WIDTH-1:0] in_world_z = '0;
  logic out_valid;
  logic signed [OUT_W-1:0] out_screen_x, out_screen_y;
  logic out_zero_depth, out_clipped;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // shadow copy of the view registers
  logic [63:0] row_cam_x, row_cam_y, row_cam_d;
  logic [11:0] dist_reg, x_off_reg, y_off_reg, rows_reg;

  screen_pt_t pending_pts[$];
  int errors = 0;
  int items_sent = 0;
  int reg_writes = 0;
  int zero_seen = 0;
  int clip_seen = 0;
  int stall_cnt = 0;
  bit calm = 1'b0;

  perspective_point_projector i_dut (
    .clk, .rst_n, .start, .busy,
    .in_world_x, .in_world_y, .in_world_z,
    .out_valid, .out_screen_x, .out_screen_y, .out_zero_depth, .out_clipped,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  function automatic longint row_dot(logic [63:0] row, longint x, longint y, longint z);
    longint c0, c1, c2, t;
    c0 = longint'($signed(row[15:0]));
    c1 = longint'($signed(row[31:16]));
    c2 = longint'($signed(row[47:32]));
    t  = longint'($signed(row[63:48]));
    return c0 * x + c1 * y + c2 * z + t * (longint'(1) << COEF_FRAC_BITS);
  endfunction

  function automatic screen_pt_t project(logic signed [15:0] x, y, z);
    screen_pt_t r;
    longint ax, ay, ad, d, vx, vy;
    ax = row_dot(row_cam_x, x, y, z);
    ay = row_dot(row_cam_y, x, y, z);
    ad = row_dot(row_cam_d, x, y, z);
    r = '{sx: '0, sy: '0, zd: 1'b1, cl: 1'b0};
    if (ad != 0) begin
      d  = longint'(dist_reg);
      vx = (d * ax) / ad + longint'(x_off_reg);
      vy = longint'(rows_reg) - ((d * ay) / ad + longint'(y_off_reg));
      r.zd = 1'b0;
      if (vx > 32767) begin
        vx = 32767; r.cl = 1'b1;
      end else if (vx < -32768) begin
        vx = -32768; r.cl = 1'b1;
      end
      if (vy > 32767) begin
        vy = 32767; r.cl = 1'b1;
      end else if (vy < -32768) begin
        vy = -32768; r.cl = 1'b1;
      end
      r.sx = vx[15:0];
      r.sy = vy[15:0];
    end
    return r;
  endfunction

  // unless calm is set, each cycle idles with a chance of about one in four
  task automatic idle_gap();
    while (!calm && $urandom_range(99) < 24) begin
      start = 1'b0;
      @(negedge clk);
    end
  endtask

  // drive one point, wait until taken, then log what it should produce
  task automatic send_point(logic signed [15:0] x, y, z, bit known, screen_pt_t typed);
    @(negedge clk);
    idle_gap();
    start = 1'b1;
    in_world_x = x;
    in_world_y = y;
    in_world_z = z;
    do @(posedge clk); while (busy);
    pending_pts.push_back(known ? typed : project(x, y, z));
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROW_X: row_cam_x = data;
      REG_ROW_Y: row_cam_y = data;
      REG_ROW_D: row_cam_d = data;
      REG_DIST:  dist_reg  = data[11:0];
      REG_X_OFF: x_off_reg = data[11:0];
      REG_Y_OFF: y_off_reg = data[11:0];
      REG_ROWS:  rows_reg  = data[11:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    screen_pt_t want;
    if (rst_n && out_valid) begin
      if (out_zero_depth) zero_seen++;
      if (out_clipped) clip_seen++;
      if (pending_pts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: x=%0d y=%0d", out_screen_x, out_screen_y);
      end else begin
        want = pending_pts.pop_front();
        if (out_screen_x !== want.sx || out_screen_y !== want.sy ||
            out_zero_depth !== want.zd || out_clipped !== want.cl) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: got x=%0d y=%0d zd=%b cl=%b, want x=%0d y=%0d zd=%b cl=%b",
                     out_screen_x, out_screen_y, out_zero_depth, out_clipped,
                     want.sx, want.sy, want.zd, want.cl);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  stim_row_t directed[] = '{
    // reset rows are all zero, so every point has zero depth
    '{ROW_POINT_KNOWN, 16'sd0, 16'sd0, 16'sd0, REG_UNUSED, 64'd0, 16'sd0, 16'sd0, 1'b1, 1'b0},
    '{ROW_POINT_KNOWN, 16'sd32767, 16'sd32767, 16'sd32767, REG_UNUSED, 64'd0,
      16'sd0, 16'sd0, 1'b1, 1'b0},
    '{ROW_POINT_KNOWN, -16'sd32768, -16'sd32768, -16'sd32768, REG_UNUSED, 64'd0,
      16'sd0, 16'sd0, 1'b1, 1'b0},
    '{ROW_REG, 16'sd0, 16'sd0, 16'sd0, REG_ROW_X, 64'h0000_0000_0000_7fff, 0, 0, 0, 0},
    '{ROW_REG, 16'sd0, 16'sd0, 16'sd0, REG_ROW_D, 64'h0000_4000_0000_0000, 0, 0, 0, 0},
    '{ROW_REG, 16'sd0, 16'sd0, 16'sd0, REG_DIST, 64'd4095, 0, 0, 0, 0},
    // large x over unit depth clamps the column
    '{ROW_POINT_KNOWN, 16'sd32767, 16'sd0, 16'sd1, REG_UNUSED, 64'd0,
      16'sd32767, 16'sd350, 1'b0, 1'b1},
    '{ROW_POINT_KNOWN, -16'sd32768, 16'sd0, 16'sd1, REG_UNUSED, 64'd0,
      -16'sd32768, 16'sd350, 1'b0, 1'b1},
    '{ROW_POINT, 16'sd100, -16'sd7, -16'sd3, REG_UNUSED, 64'd0, 0, 0, 0, 0},
    '{ROW_REG, 16'sd0, 16'sd0, 16'sd0, REG_ROW_Y, 64'hfff0_0000_c000_0001, 0, 0, 0, 0},
    '{ROW_POINT, 16'sd5, 16'sd300, 16'sd9, REG_UNUSED, 64'd0, 0, 0, 0, 0},
    '{ROW_POINT_KNOWN, 16'sd9, 16'sd9, 16'sd0, REG_UNUSED, 64'd0, 16'sd0, 16'sd0, 1'b1, 1'b0},
    // wide write leaves a zero plane distance
    '{ROW_REG, 16'sd0, 16'sd0, 16'sd0, REG_DIST, 64'hffff_ffff_ffff_f000, 0, 0, 0, 0},
    '{ROW_POINT_KNOWN, 16'sd1234, 16'sd321, 16'sd17, REG_UNUSED, 64'd0,
      16'sd350, 16'sd350, 1'b0, 1'b0},
    // out of range index changes nothing
    '{ROW_REG, 16'sd0, 16'sd0, 16'sd0, REG_UNUSED, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0},
    '{ROW_REG, 16'sd0, 16'sd0, 16'sd0, REG_X_OFF, 64'hffff_ffff_ffff_f123, 0, 0, 0, 0},
    '{ROW_REG, 16'sd0, 16'sd0, 16'sd0, REG_DIST, 64'd1, 0, 0, 0, 0},
    '{ROW_POINT, 16'sd77, -16'sd5, 16'sd2, REG_UNUSED, 64'd0, 0, 0, 0, 0},
    '{ROW_POINT, -16'sd1, 16'sd1, -16'sd1, REG_UNUSED, 64'd0, 0, 0, 0, 0}
  };

  function automatic logic [63:0] rand_row(bit depth);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(3) != 0) begin
      // moderate coefficients, the usual rotation range
      r[15:0]  = 16'($signed($urandom_range(32768)) - 16384);
      r[31:16] = 16'($signed($urandom_range(32768)) - 16384);
      r[47:32] = 16'($signed($urandom_range(32768)) - 16384);
      r[63:48] = depth ? 16'($urandom_range(2000)) : 16'($signed($urandom_range(400)) - 200);
    end
    if (depth && $urandom_range(7) == 0) r[47:0] = '0;
    return r;
  endfunction

  task automatic new_view(int phase);
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    write_reg(REG_ROW_X, rand_row(1'b0));
    write_reg(REG_ROW_Y, rand_row(1'b0));
    write_reg(REG_ROW_D, rand_row(1'b1));
    case (phase)
      0: begin
        write_reg(REG_DIST, 64'd4095); write_reg(REG_X_OFF, 64'd4095);
        write_reg(REG_Y_OFF, 64'd4095); write_reg(REG_ROWS, 64'd4095);
      end
      1: begin
        write_reg(REG_DIST, 64'd1); write_reg(REG_X_OFF, 64'd0);
        write_reg(REG_Y_OFF, 64'd0); write_reg(REG_ROWS, 64'd0);
      end
      2: begin
        write_reg(REG_ROW_X, 64'hffff_ffff_ffff_ffff);
        write_reg(REG_ROW_D, 64'h8000_8000_8000_8000);
        write_reg(REG_DIST, wide); write_reg(REG_X_OFF, ~wide);
        write_reg(REG_Y_OFF, wide); write_reg(REG_ROWS, ~wide);
      end
      default: begin
        write_reg(REG_DIST, 64'($urandom_range(4095, 1)));
        write_reg(REG_X_OFF, 64'($urandom_range(4095)));
        write_reg(REG_Y_OFF, 64'($urandom_range(4095)));
        write_reg(REG_ROWS, 64'($urandom_range(4095)));
      end
    endcase
  endtask

  initial begin
    screen_pt_t typed;
    row_cam_x = '0; row_cam_y = '0; row_cam_d = '0;
    dist_reg = 12'd200; x_off_reg = 12'd350; y_off_reg = 12'd350; rows_reg = 12'd700;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG) begin
        drain();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        typed = '{sx: directed[i].sx, sy: directed[i].sy, zd: directed[i].zd,
                  cl: directed[i].cl};
        send_point(directed[i].x, directed[i].y, directed[i].z,
                   directed[i].kind == ROW_POINT_KNOWN, typed);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      new_view(p);
      calm = (p == 4);
      for (int k = 0; k < PTS_PER_PHASE; k++) begin
        if ($urandom_range(3) == 0)
          send_point(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, typed);
        else
          send_point(16'($signed($urandom_range(4000)) - 2000),
                     16'($signed($urandom_range(4000)) - 2000),
                     16'($signed($urandom_range(4000)) - 2000), 1'b0, typed);
      end
    end
    drain();

    $display("covered %0d points over %0d register writes", items_sent, reg_writes);
    $display("results with zero depth: %0d, clamped: %0d", zero_seen, clip_seen);
    if (errors == 0 && pending_pts.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ppp_pkg.sv
rtl/ppp_front.sv
rtl/ppp_div_cell.sv
rtl/perspective_point_projector.sv
rtl/ppp_checker.sv
verif/testbench.sv
